[rtl/srank_pkg.sv]
package srank_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int SCORE_BITS = 20;
	localparam int ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

	localparam int POS_W   = 6;
	localparam int PLACE_W = 7;
	localparam int MEDAL_W = 2;

	localparam logic [MEDAL_W-1:0] MEDAL_NONE   = 2'd0;
	localparam logic [MEDAL_W-1:0] MEDAL_GOLD   = 2'd1;
	localparam logic [MEDAL_W-1:0] MEDAL_SILVER = 2'd2;
	localparam logic [MEDAL_W-1:0] MEDAL_BRONZE = 2'd3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RDCUR,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic rd_cur;
		logic sweep;
		logic drain;
		logic next_i;
	} cmd_t;

	typedef struct packed {
		logic sweep_end;
		logic out_taken;
		logic last_res;
	} status_t;

	function automatic logic [MEDAL_W-1:0] medal_of(input logic [PLACE_W-1:0] place);
		logic [MEDAL_W-1:0] m;
		case (place)
			7'd1:    m = MEDAL_GOLD;
			7'd2:    m = MEDAL_SILVER;
			7'd3:    m = MEDAL_BRONZE;
			default: m = MEDAL_NONE;
		endcase
		return m;
	endfunction

endpackage

[rtl/srank_ctrl.sv]
module srank_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	input  srank_pkg::status_t   status,
	output srank_pkg::cmd_t      cmd
);

	srank_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srank_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srank_pkg::ST_LOAD: begin
				if (in_valid && in_last) state_d = srank_pkg::ST_RDCUR;
			end
			srank_pkg::ST_RDCUR: begin
				state_d = srank_pkg::ST_SWEEP;
			end
			srank_pkg::ST_SWEEP: begin
				if (status.sweep_end) state_d = srank_pkg::ST_DRAIN;
			end
			srank_pkg::ST_DRAIN: begin
				state_d = srank_pkg::ST_EMIT;
			end
			srank_pkg::ST_EMIT: begin
				if (status.out_taken) begin
					state_d = status.last_res ? srank_pkg::ST_LOAD : srank_pkg::ST_RDCUR;
				end
			end
			default: state_d = srank_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			srank_pkg::ST_LOAD:  cmd.in_ready = 1'b1;
			srank_pkg::ST_RDCUR: cmd.rd_cur   = 1'b1;
			srank_pkg::ST_SWEEP: cmd.sweep    = 1'b1;
			srank_pkg::ST_DRAIN: cmd.drain    = 1'b1;
			srank_pkg::ST_EMIT:  cmd.next_i   = status.out_taken & ~status.last_res;
			default:             cmd = '0;
		endcase
	end

endmodule

[rtl/srank_dp.sv]
module srank_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  srank_pkg::cmd_t                      cmd,
	input  logic                                 in_valid,
	input  logic                                 in_last,
	input  logic [srank_pkg::SCORE_BITS-1:0]     in_score,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [srank_pkg::POS_W-1:0]          out_position,
	output logic [srank_pkg::PLACE_W-1:0]        out_placement,
	output logic [srank_pkg::MEDAL_W-1:0]        out_medal,
	output logic                                 out_last,
	output srank_pkg::status_t                   status
);

	logic [srank_pkg::SCORE_BITS-1:0] mem [srank_pkg::MAX_ITEMS];

	logic [srank_pkg::CNT_BITS-1:0]   cnt_q;
	logic [srank_pkg::CNT_BITS-1:0]   n_q;
	logic [srank_pkg::ADDR_BITS-1:0]  i_q;
	logic [srank_pkg::ADDR_BITS-1:0]  k_q;
	logic [srank_pkg::CNT_BITS-1:0]   acc_q;
	logic [srank_pkg::SCORE_BITS-1:0] a_data_q;
	logic [srank_pkg::SCORE_BITS-1:0] b_data_s1;
	logic                             b_v_s1;

	logic [srank_pkg::PLACE_W-1:0]    place_q;
	logic [srank_pkg::POS_W-1:0]      pos_q;
	logic                             last_q;
	logic                             valid_q;

	logic                             in_fire;
	logic                             room;
	logic [srank_pkg::CNT_BITS-1:0]   cnt_next;
	logic [srank_pkg::CNT_BITS-1:0]   n_m1;
	logic [srank_pkg::CNT_BITS-1:0]   acc_next;
	logic [srank_pkg::PLACE_W-1:0]    place_new;

	assign in_fire   = cmd.in_ready & in_valid;
	assign room      = (cnt_q < srank_pkg::CNT_BITS'(srank_pkg::MAX_ITEMS));
	assign cnt_next  = room ? cnt_q + 1'b1 : cnt_q;
	assign n_m1      = n_q - 1'b1;
	assign acc_next  = acc_q + srank_pkg::CNT_BITS'(b_v_s1 && (b_data_s1 >= a_data_q));
	assign place_new = srank_pkg::PLACE_W'(acc_next);

	always_ff @(posedge clk) begin
		if (in_fire && room) mem[cnt_q[srank_pkg::ADDR_BITS-1:0]] <= in_score;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_cur) a_data_q  <= mem[i_q];
		if (cmd.sweep)  b_data_s1 <= mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
			acc_q   <= '0;
			b_v_s1  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (in_last) begin
					// close the set: remember its size, empty the store
					n_q   <= cnt_next;
					cnt_q <= '0;
					i_q   <= '0;
				end else begin
					cnt_q <= cnt_next;
				end
			end
			if (cmd.next_i) i_q <= i_q + 1'b1;
			if (cmd.rd_cur) begin
				k_q   <= '0;
				acc_q <= '0;
			end else if (b_v_s1) begin
				acc_q <= acc_next;
			end
			if (cmd.sweep) k_q <= k_q + 1'b1;
			b_v_s1 <= cmd.sweep;
			if (cmd.drain) valid_q <= 1'b1;
			else if (valid_q && out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			place_q <= place_new;
			pos_q   <= srank_pkg::POS_W'(i_q);
			last_q  <= (srank_pkg::CNT_BITS'(i_q) == n_m1);
		end
	end

	assign out_valid     = valid_q;
	assign out_position  = pos_q;
	assign out_placement = place_q;
	assign out_medal     = srank_pkg::medal_of(place_q);
	assign out_last      = last_q;

	assign status.sweep_end = (srank_pkg::CNT_BITS'(k_q) == n_m1);
	assign status.out_taken = valid_q & out_ready;
	assign status.last_res  = last_q;

`ifndef ASSERT_OFF
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= srank_pkg::CNT_BITS'(srank_pkg::MAX_ITEMS))
		else $error("stored count beyond capacity");
	a_place_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (place_q >= 7'd1) && (place_q <= srank_pkg::PLACE_W'(n_q)))
		else $error("placement outside the set");
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		b_v_s1 |-> acc_q < n_q)
		else $error("count of hits overruns the set");
	a_pos_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> srank_pkg::CNT_BITS'(pos_q) < n_q)
		else $error("result index outside the set");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.in_ready |-> !valid_q && !b_v_s1))
		else $error("input taken while a result is in work");
`endif

endmodule

[rtl/score_rank_assigner.sv]
// Channel  Dir  Fields (tdata low bit up)                      tlast
// s_*      in   score[19:0], zero fill to 24 bits               is_last
// m_*      out  position[5:0] placement[12:6] medal[14:13] pad  last_result
//
// Scores are taken one per cycle while the block is in its load state. After the
// closing item each result passes through a read of its score, a sweep of the
// store through one comparator and a drain step, plus any wait on m_tready; one
// read port feeds the sweep. No new item is taken until the last result of the
// run has gone.
// Reset clears the count and the controller; the score store needs no clear.
module score_rank_assigner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // score[19:0], zero [23:20]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // position[5:0], placement[12:6], medal[14:13], zero [15]
	output logic        m_tlast
);

	srank_pkg::cmd_t    cmd;
	srank_pkg::status_t status;

	logic [srank_pkg::POS_W-1:0]   position;
	logic [srank_pkg::PLACE_W-1:0] placement;
	logic [srank_pkg::MEDAL_W-1:0] medal;

	srank_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	srank_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_valid      (s_tvalid),
		.in_last       (s_tlast),
		.in_score      (s_tdata[srank_pkg::SCORE_BITS-1:0]),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_position  (position),
		.out_placement (placement),
		.out_medal     (medal),
		.out_last      (m_tlast),
		.status        (status)
	);

	assign s_tready = cmd.in_ready;
	assign m_tdata  = {1'b0, medal, placement, position};

endmodule
